### design/gtvp_pkg.sv
package gtvp_pkg;

    // CORDIC chain length used when the top level is not overridden
    localparam int CORDIC_STEPS_DEF = 24;

    // Angle constants, Q2.30 radians (unsigned magnitudes)
    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    // CORDIC start vector length, 0.60725 in Q1.30
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;

    // Angle constants, Q8.24 radians
    localparam logic [31:0] TWO_PI_Q24 = 32'd105414357;
    localparam logic [31:0] PI_Q24     = 32'd52707179;

    // Width of the CORDIC x, y and z datapath
    localparam int ROT_W = 34;

    // Number of reduction cells: |th| * 64 stays below 64 * 2pi in Q2.30
    localparam int RED_CELLS = 6;

    // Width of the angle magnitude during reduction
    localparam int MAG_W = 39;

    typedef enum logic [2:0] {
        CFG_REF_X      = 3'd0,
        CFG_REF_Y      = 3'd1,
        CFG_REF_YAW    = 3'd2,
        CFG_OFFSET_X   = 3'd3,
        CFG_OFFSET_Y   = 3'd4,
        CFG_OFFSET_YAW = 3'd5,
        CFG_USE_OFFSET = 3'd6
    } t_cfg_idx;

    // Pose difference carried along the chain
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] yaw;
    } t_pose;

    // Rotation angle during reduction: sign and magnitude
    typedef struct packed {
        logic             sign;
        logic [MAG_W-1:0] mag;
    } t_ang;

    // CORDIC vector and residual angle
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic                    flip;
    } t_rot;

    // Offset pose for the output stages
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] yaw;
        logic               use_offset;
    } t_ofs;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [38:0] v);
        logic [31:0] r;
        if (v > 39'sh7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -39'sh8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### design/gtvp_reduce_cell.sv
// One restoring step of the angle reduction: drop 2^SHIFT times 2pi if it fits.
module gtvp_reduce_cell #(
    parameter int SHIFT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gtvp_pkg::t_pose   i_pose,
    input  gtvp_pkg::t_ang    i_ang,
    output logic              o_valid,
    input  logic              i_ready,
    output gtvp_pkg::t_pose   o_pose,
    output gtvp_pkg::t_ang    o_ang
);

    localparam logic [gtvp_pkg::MAG_W-1:0] SUB =
        gtvp_pkg::MAG_W'(gtvp_pkg::TWO_PI_Q30) << SHIFT;

    logic            r_valid;
    gtvp_pkg::t_pose r_pose;
    gtvp_pkg::t_ang  r_ang;
    gtvp_pkg::t_ang  n_ang;
    logic            load;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;

    always_comb begin
        n_ang = i_ang;
        if (i_ang.mag >= SUB) begin
            n_ang.mag = i_ang.mag - SUB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_pose <= i_pose;
            r_ang  <= n_ang;
        end
    end

    assign o_valid = r_valid;
    assign o_pose  = r_pose;
    assign o_ang   = r_ang;

endmodule

### design/gtvp_angle_fold.sv
// Wrap the reduced angle into [-pi, pi], fold it into [-pi/2, pi/2] and
// seed the CORDIC vector. Two stages.
module gtvp_angle_fold (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gtvp_pkg::t_pose   i_pose,
    input  gtvp_pkg::t_ang    i_ang,
    output logic              o_valid,
    input  logic              i_ready,
    output gtvp_pkg::t_pose   o_pose,
    output gtvp_pkg::t_rot    o_rot
);

    localparam int RW = gtvp_pkg::ROT_W;

    logic               r_valid_a;
    logic               r_valid_b;
    gtvp_pkg::t_pose    r_pose_a;
    gtvp_pkg::t_pose    r_pose_b;
    logic               r_sign_a;
    logic signed [34:0] r_m;
    gtvp_pkg::t_rot     r_rot;

    logic               load_a;
    logic               load_b;
    logic [33:0]        rem;
    logic signed [34:0] n_m;
    logic signed [34:0] pi_s;
    logic signed [34:0] hp_s;
    logic signed [34:0] f;
    logic               fold_up;
    logic               fold_dn;
    gtvp_pkg::t_rot     n_rot;

    assign load_b  = !r_valid_b || i_ready;
    assign load_a  = !r_valid_a || load_b;
    assign o_ready = load_a;

    assign rem  = i_ang.mag[33:0];
    assign pi_s = $signed(35'(gtvp_pkg::PI_Q30));
    assign hp_s = $signed(35'(gtvp_pkg::HALF_PI_Q30));

    // Wrap in the magnitude domain; the sign is applied after the fold
    assign n_m = (rem > 34'(gtvp_pkg::PI_Q30))
        ? $signed(35'(rem)) - $signed(35'(gtvp_pkg::TWO_PI_Q30))
        : $signed(35'(rem));

    assign fold_up = r_m > hp_s;
    assign fold_dn = r_m < -hp_s;

    always_comb begin
        if (fold_up) begin
            f = r_sign_a ? pi_s - r_m : r_m - pi_s;
        end else if (fold_dn) begin
            f = r_sign_a ? -r_m - pi_s : r_m + pi_s;
        end else begin
            f = r_sign_a ? -r_m : r_m;
        end
        n_rot.x    = $signed(RW'(gtvp_pkg::GAIN_Q30));
        n_rot.y    = '0;
        n_rot.z    = RW'(f);
        n_rot.flip = fold_up || fold_dn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (load_a) begin
                r_valid_a <= i_valid;
            end
            if (load_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a && i_valid) begin
            r_pose_a <= i_pose;
            r_sign_a <= i_ang.sign;
            r_m      <= n_m;
        end
        if (load_b && r_valid_a) begin
            r_pose_b <= r_pose_a;
            r_rot    <= n_rot;
        end
    end

    assign o_valid = r_valid_b;
    assign o_pose  = r_pose_b;
    assign o_rot   = r_rot;

endmodule

### design/gtvp_cordic_cell.sv
// One rotation-mode CORDIC iteration.
module gtvp_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gtvp_pkg::t_pose   i_pose,
    input  gtvp_pkg::t_rot    i_rot,
    output logic              o_valid,
    input  logic              i_ready,
    output gtvp_pkg::t_pose   o_pose,
    output gtvp_pkg::t_rot    o_rot
);

    localparam int RW = gtvp_pkg::ROT_W;
    localparam logic signed [RW-1:0] ATAN =
        $signed(RW'(gtvp_pkg::atan_q30(5'(STEP))));

    logic                   r_valid;
    gtvp_pkg::t_pose        r_pose;
    gtvp_pkg::t_rot         r_rot;
    gtvp_pkg::t_rot         n_rot;
    logic signed [RW-1:0]   xs;
    logic signed [RW-1:0]   ys;
    logic                   load;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;

    assign xs = i_rot.x >>> STEP;
    assign ys = i_rot.y >>> STEP;

    always_comb begin
        n_rot.flip = i_rot.flip;
        if (!i_rot.z[RW-1]) begin
            n_rot.x = i_rot.x - ys;
            n_rot.y = i_rot.y + xs;
            n_rot.z = i_rot.z - ATAN;
        end else begin
            n_rot.x = i_rot.x + ys;
            n_rot.y = i_rot.y - xs;
            n_rot.z = i_rot.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_pose <= i_pose;
            r_rot  <= n_rot;
        end
    end

    assign o_valid = r_valid;
    assign o_pose  = r_pose;
    assign o_rot   = r_rot;

endmodule

### design/gtvp_out_stage.sv
// Rotate, round, apply offset or pi wrap, saturate. Five stages, the last
// one is the output register.
module gtvp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gtvp_pkg::t_pose   i_pose,
    input  gtvp_pkg::t_rot    i_rot,
    input  gtvp_pkg::t_ofs    i_ofs,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_out_x,
    output logic [31:0]       o_out_y,
    output logic [31:0]       o_out_yaw
);

    localparam int RW = gtvp_pkg::ROT_W;
    localparam int NS = 5;

    logic [NS-1:0]          r_v;
    logic [NS:0]            rdy;

    // stage 0: cos and sin
    gtvp_pkg::t_pose        r0_pose;
    logic signed [RW-1:0]   r0_c;
    logic signed [RW-1:0]   r0_s;
    // stage 1: products
    logic signed [66:0]     r1_xc;
    logic signed [66:0]     r1_ys;
    logic signed [66:0]     r1_xs;
    logic signed [66:0]     r1_yc;
    logic signed [32:0]     r1_yaw;
    // stage 2: rounded products, first yaw step
    logic signed [36:0]     r2_xc;
    logic signed [36:0]     r2_ys;
    logic signed [36:0]     r2_xs;
    logic signed [36:0]     r2_yc;
    logic signed [33:0]     r2_yaw;
    // stage 3: sums, pi wrap or yaw offset
    logic signed [37:0]     r3_x;
    logic signed [37:0]     r3_y;
    logic signed [34:0]     r3_yaw;
    // stage 4: output register
    logic [31:0]            r4_x;
    logic [31:0]            r4_y;
    logic [31:0]            r4_yaw;

    logic signed [33:0]     two_pi_24;
    logic signed [33:0]     pi_24;
    logic signed [33:0]     yaw_ext;
    logic signed [33:0]     n2_yaw;
    logic signed [34:0]     n3_yaw;
    logic signed [38:0]     n4_x;
    logic signed [38:0]     n4_y;

    always_comb begin
        rdy[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    function automatic logic signed [36:0] round_q30(input logic signed [66:0] p);
        logic signed [66:0] t;
        t = p + 67'sh2000_0000;
        return 37'(t >>> 30);
    endfunction

    assign two_pi_24 = $signed(34'(gtvp_pkg::TWO_PI_Q24));
    assign pi_24     = $signed(34'(gtvp_pkg::PI_Q24));
    assign yaw_ext   = 34'(r1_yaw);

    always_comb begin
        if (yaw_ext > two_pi_24) begin
            n2_yaw = yaw_ext - two_pi_24;
        end else if (yaw_ext < -two_pi_24) begin
            n2_yaw = yaw_ext + two_pi_24;
        end else begin
            n2_yaw = yaw_ext;
        end
    end

    always_comb begin
        if (i_ofs.use_offset) begin
            n3_yaw = 35'(r2_yaw) + 35'(i_ofs.yaw);
        end else if (r2_yaw > pi_24) begin
            n3_yaw = 35'(r2_yaw) - 35'(two_pi_24);
        end else if (r2_yaw < -pi_24) begin
            n3_yaw = 35'(r2_yaw) + 35'(two_pi_24);
        end else begin
            n3_yaw = 35'(r2_yaw);
        end
    end

    assign n4_x = i_ofs.use_offset ? 39'(r3_x) + 39'(i_ofs.x) : 39'(r3_x);
    assign n4_y = i_ofs.use_offset ? 39'(r3_y) + 39'(i_ofs.y) : 39'(r3_y);

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r0_pose <= i_pose;
            r0_c    <= i_rot.flip ? -i_rot.x : i_rot.x;
            r0_s    <= i_rot.flip ? -i_rot.y : i_rot.y;
        end
        if (rdy[1] && r_v[0]) begin
            r1_xc  <= r0_pose.dx * r0_c;
            r1_ys  <= r0_pose.dy * r0_s;
            r1_xs  <= r0_pose.dx * r0_s;
            r1_yc  <= r0_pose.dy * r0_c;
            r1_yaw <= r0_pose.yaw;
        end
        if (rdy[2] && r_v[1]) begin
            r2_xc  <= round_q30(r1_xc);
            r2_ys  <= round_q30(r1_ys);
            r2_xs  <= round_q30(r1_xs);
            r2_yc  <= round_q30(r1_yc);
            r2_yaw <= n2_yaw;
        end
        if (rdy[3] && r_v[2]) begin
            r3_x   <= 38'(r2_xc) + 38'(r2_ys);
            r3_y   <= 38'(r2_xs) - 38'(r2_yc);
            r3_yaw <= n3_yaw;
        end
        if (rdy[4] && r_v[3]) begin
            r4_x   <= gtvp_pkg::sat32(n4_x);
            r4_y   <= gtvp_pkg::sat32(n4_y);
            r4_yaw <= gtvp_pkg::sat32(39'(r3_yaw));
        end
    end

    assign o_valid   = r_v[NS-1];
    assign o_out_x   = r4_x;
    assign o_out_y   = r4_y;
    assign o_out_yaw = r4_yaw;

endmodule

### design/gps_to_vehicle_pose_transform.sv
// Throughput: one pose per cycle unless stalled; depth grows with the CORDIC cell chain.
// Every stage has its own valid bit and loads whenever it is empty or its content moves on,
// so bubbles close up and input is taken while a result waits at the output register.
// Reset (synchronous, i_rst_n low) empties the pipeline and loads the configuration
// defaults: all offsets and the reference pose zero, offset mode on.
module gps_to_vehicle_pose_transform #(
    parameter int CORDIC_STEPS = gtvp_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pose input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_yaw,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_yaw,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NR = gtvp_pkg::RED_CELLS;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the
    // pipeline is empty; the block does not enforce this. The stages read them directly.
    // ------------------------------------------------------------------
    logic signed [31:0] r_ref_x;
    logic signed [31:0] r_ref_y;
    logic signed [31:0] r_ref_yaw;
    logic signed [31:0] r_offset_x;
    logic signed [31:0] r_offset_y;
    logic signed [31:0] r_offset_yaw;
    logic               r_use_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x      <= '0;
            r_ref_y      <= '0;
            r_ref_yaw    <= '0;
            r_offset_x   <= '0;
            r_offset_y   <= '0;
            r_offset_yaw <= '0;
            r_use_offset <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (gtvp_pkg::t_cfg_idx'(i_cfg_index))
                gtvp_pkg::CFG_REF_X:      r_ref_x      <= i_cfg_data;
                gtvp_pkg::CFG_REF_Y:      r_ref_y      <= i_cfg_data;
                gtvp_pkg::CFG_REF_YAW:    r_ref_yaw    <= i_cfg_data;
                gtvp_pkg::CFG_OFFSET_X:   r_offset_x   <= i_cfg_data;
                gtvp_pkg::CFG_OFFSET_Y:   r_offset_y   <= i_cfg_data;
                gtvp_pkg::CFG_OFFSET_YAW: r_offset_yaw <= i_cfg_data;
                gtvp_pkg::CFG_USE_OFFSET: r_use_offset <= i_cfg_data[0];
                default: ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Entry stage: exact 33-bit differences, and the rotation angle as
    // sign and magnitude scaled to Q2.30 (times 64 is a 6-bit shift).
    // ------------------------------------------------------------------
    logic               r_e_valid;
    gtvp_pkg::t_pose    r_e_pose;
    gtvp_pkg::t_ang     r_e_ang;
    logic               e_ready;
    gtvp_pkg::t_pose    n_e_pose;
    gtvp_pkg::t_ang     n_e_ang;
    logic signed [32:0] th;
    logic [32:0]        th_mag;

    assign th = 33'(r_ref_yaw) + (r_use_offset ? 33'(r_offset_yaw) : 33'sd0);
    assign th_mag = th[32] ? 33'(-th) : 33'(th);

    always_comb begin
        n_e_pose.dx  = 33'($signed(i_target_x)) - 33'(r_ref_x);
        n_e_pose.dy  = 33'($signed(i_target_y)) - 33'(r_ref_y);
        n_e_pose.yaw = 33'(r_ref_yaw) - 33'($signed(i_target_yaw));
        n_e_ang.sign = th[32];
        n_e_ang.mag  = {th_mag, 6'b0};
    end

    // ------------------------------------------------------------------
    // Chain wiring: reduction cells, angle fold, CORDIC cells, output.
    // ------------------------------------------------------------------
    logic                  red_valid [0:NR];
    logic                  red_ready [0:NR];
    gtvp_pkg::t_pose       red_pose  [0:NR];
    gtvp_pkg::t_ang        red_ang   [0:NR];

    logic                  cor_valid [0:CORDIC_STEPS];
    logic                  cor_ready [0:CORDIC_STEPS];
    gtvp_pkg::t_pose       cor_pose  [0:CORDIC_STEPS];
    gtvp_pkg::t_rot        cor_rot   [0:CORDIC_STEPS];

    gtvp_pkg::t_ofs        ofs;

    // entry stage loads when empty or when its pose moves into the chain
    assign e_ready = !r_e_valid || red_ready[0];
    assign o_stall = !e_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (e_ready) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_ready && i_valid) begin
            r_e_pose <= n_e_pose;
            r_e_ang  <= n_e_ang;
        end
    end

    assign red_valid[0] = r_e_valid;
    assign red_pose[0]  = r_e_pose;
    assign red_ang[0]   = r_e_ang;

    // Truncating remainder by 2pi: subtract 32, 16, ... 1 times 2pi in turn
    for (genvar k = 0; k < NR; k++) begin : g_red
        gtvp_reduce_cell #(
            .SHIFT (NR - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (red_valid[k]),
            .o_ready (red_ready[k]),
            .i_pose  (red_pose[k]),
            .i_ang   (red_ang[k]),
            .o_valid (red_valid[k+1]),
            .i_ready (red_ready[k+1]),
            .o_pose  (red_pose[k+1]),
            .o_ang   (red_ang[k+1])
        );
    end

    gtvp_angle_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (red_valid[NR]),
        .o_ready (red_ready[NR]),
        .i_pose  (red_pose[NR]),
        .i_ang   (red_ang[NR]),
        .o_valid (cor_valid[0]),
        .i_ready (cor_ready[0]),
        .o_pose  (cor_pose[0]),
        .o_rot   (cor_rot[0])
    );

    // One CORDIC iteration per cell; the vector advances every cycle unless the chain is stalled
    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cor
        gtvp_cordic_cell #(
            .STEP (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cor_valid[j]),
            .o_ready (cor_ready[j]),
            .i_pose  (cor_pose[j]),
            .i_rot   (cor_rot[j]),
            .o_valid (cor_valid[j+1]),
            .i_ready (cor_ready[j+1]),
            .o_pose  (cor_pose[j+1]),
            .o_rot   (cor_rot[j+1])
        );
    end

    assign ofs.x          = r_offset_x;
    assign ofs.y          = r_offset_y;
    assign ofs.yaw        = r_offset_yaw;
    assign ofs.use_offset = r_use_offset;

    gtvp_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (cor_valid[CORDIC_STEPS]),
        .o_ready   (cor_ready[CORDIC_STEPS]),
        .i_pose    (cor_pose[CORDIC_STEPS]),
        .i_rot     (cor_rot[CORDIC_STEPS]),
        .i_ofs     (ofs),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out_x   (o_out_x),
        .o_out_y   (o_out_y),
        .o_out_yaw (o_out_yaw)
    );

endmodule

### design/gtvp_checker.sv
module gtvp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_out_x,
    input logic [31:0] o_out_y,
    input logic [31:0] o_out_yaw
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_out_yaw))
        else $error("stalled result changed");

    // input backs up only when the output register is full and stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with output free");

endmodule

bind gps_to_vehicle_pose_transform gtvp_checker u_gtvp_checker (.*);

### sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Rotation chain length; the block is built with the same value
    localparam int ROT_STEPS = 24;

    // Angle constants for the expected-pose math, Q2.30 and Q8.24 radians
    localparam longint TWO_PI_Q30_TB  = 64'sd6746518852;
    localparam longint PI_Q30_TB      = 64'sd3373259426;
    localparam longint HALF_PI_Q30_TB = 64'sd1686629713;
    localparam longint GAIN_Q30_TB    = 64'sd652032874;
    localparam longint TWO_PI_Q24_TB  = 64'sd105414357;
    localparam longint PI_Q24_TB      = 64'sd52707179;
    localparam longint ROUND_HALF     = 64'sd536870912;

    // Stimulus-side angle constants, Q8.24
    localparam logic [31:0] TWO_PI_A  = 32'd105414357;
    localparam logic [31:0] PI_A      = 32'd52707179;
    localparam logic [31:0] HALF_PI_A = 32'd26353590;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    // The only index the register file does not decode
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 92;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] yaw;
    } t_target_pose;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [31:0] i_target_x   = '0;
    logic [31:0] i_target_y   = '0;
    logic [31:0] i_target_yaw = '0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_yaw;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index  = '0;
    logic [31:0] i_cfg_data   = '0;

    gps_to_vehicle_pose_transform #(
        .CORDIC_STEPS(ROT_STEPS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_target_x  (i_target_x),
        .i_target_y  (i_target_y),
        .i_target_yaw(i_target_yaw),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_yaw   (o_out_yaw),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the register file, tracked as writes are accepted
    logic signed [31:0] ref_x_r      = '0;
    logic signed [31:0] ref_y_r      = '0;
    logic signed [31:0] ref_yaw_r    = '0;
    logic signed [31:0] offset_x_r   = '0;
    logic signed [31:0] offset_y_r   = '0;
    logic signed [31:0] offset_yaw_r = '0;
    logic               use_offset_r = 1'b1;

    // atan(2^-i) in Q2.30
    longint atan_tab [0:31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    t_target_pose gps_targets[$];        // poses waiting to be offered to the block
    t_target_pose vehicle_poses_due[$];  // expected vehicle-frame poses, oldest first

    int send_idle_pct = 7;
    int recv_stall_pct = 65;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Clamp a wide result into the signed 32-bit range
    function automatic logic [31:0] clamp_word(input longint v);
        if (v > 64'sd2147483647) return WORD_MAX;
        if (v < -64'sd2147483648) return WORD_MIN;
        return v[31:0];
    endfunction

    // Compute the vehicle-frame pose for one GPS target under the current settings
    function automatic t_target_pose to_vehicle_frame(input t_target_pose tgt);
        longint dx, dy, yaw, th, z, cx, sy, nx, ox, oy;
        bit     flip;
        int     i;
        t_target_pose res;
        dx  = longint'($signed(tgt.x)) - longint'(ref_x_r);
        dy  = longint'($signed(tgt.y)) - longint'(ref_y_r);
        yaw = longint'(ref_yaw_r) - longint'($signed(tgt.yaw));
        th  = use_offset_r ? longint'(ref_yaw_r) + longint'(offset_yaw_r)
                           : longint'(ref_yaw_r);

        // Reduce the heading into [-pi, pi], then fold it into [-pi/2, pi/2]
        z = (th * 64) % TWO_PI_Q30_TB;
        if (z > PI_Q30_TB) z -= TWO_PI_Q30_TB;
        if (z < -PI_Q30_TB) z += TWO_PI_Q30_TB;
        flip = 1'b0;
        if (z > HALF_PI_Q30_TB) begin
            z -= PI_Q30_TB;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30_TB) begin
            z += PI_Q30_TB;
            flip = 1'b1;
        end

        cx = GAIN_Q30_TB;
        sy = 0;
        for (i = 0; i < ROT_STEPS && i < 32; i++) begin
            if (z >= 0) begin
                nx = cx - (sy >>> i);
                sy = sy + (cx >>> i);
                z -= atan_tab[i];
            end else begin
                nx = cx + (sy >>> i);
                sy = sy - (cx >>> i);
                z += atan_tab[i];
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end

        ox = ((dx * cx + ROUND_HALF) >>> 30) + ((dy * sy + ROUND_HALF) >>> 30);
        oy = ((dx * sy + ROUND_HALF) >>> 30) - ((dy * cx + ROUND_HALF) >>> 30);

        // One correction step by 2*pi only
        if (yaw > TWO_PI_Q24_TB) yaw -= TWO_PI_Q24_TB;
        if (yaw < -TWO_PI_Q24_TB) yaw += TWO_PI_Q24_TB;

        if (use_offset_r) begin
            ox  += longint'(offset_x_r);
            oy  += longint'(offset_y_r);
            yaw += longint'(offset_yaw_r);
        end else begin
            if (yaw > PI_Q24_TB) yaw -= TWO_PI_Q24_TB;
            if (yaw < -PI_Q24_TB) yaw += TWO_PI_Q24_TB;
        end

        res.x   = clamp_word(ox);
        res.y   = clamp_word(oy);
        res.yaw = clamp_word(yaw);
        return res;
    endfunction

    // Position pick: extremes, full-range words and moderate distances
    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
        endcase
    endfunction

    // Angle pick: extremes, full-range words, multiples of pi/2 give or take a few LSBs
    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2, 3:    return $urandom;
            4, 5:    return HALF_PI_A * ($urandom_range(0, 16) - 8) + $urandom_range(0, 6) - 3;
            default: return $urandom_range(0, 4 * TWO_PI_A) - 2 * TWO_PI_A;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endtask

    task automatic queue_target(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] yaw);
        t_target_pose p;
        p.x   = x;
        p.y   = y;
        p.yaw = yaw;
        gps_targets.insert(gps_targets.size(), p);
    endtask

    // Block until every queued pose went in and every expected pose came out
    task automatic wait_idle();
        while (gps_targets.size() != 0 || vehicle_poses_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Write one register and mirror it into the shadow copy once the transfer happens
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            gtvp_pkg::CFG_REF_X:      ref_x_r      = val;
            gtvp_pkg::CFG_REF_Y:      ref_y_r      = val;
            gtvp_pkg::CFG_REF_YAW:    ref_yaw_r    = val;
            gtvp_pkg::CFG_OFFSET_X:   offset_x_r   = val;
            gtvp_pkg::CFG_OFFSET_Y:   offset_y_r   = val;
            gtvp_pkg::CFG_OFFSET_YAW: offset_yaw_r = val;
            gtvp_pkg::CFG_USE_OFFSET: use_offset_r = val[0];
            default: ;  // undecoded index: nothing changes
        endcase
    endtask

    // Driver: on a transfer, predict the result and drop the pose from the queue;
    // when the port is free, offer the next pose or idle at random.
    // Hold the payload steady while the block stalls.
    always @(posedge i_clk) begin
        t_target_pose cur;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                cur.x   = i_target_x;
                cur.y   = i_target_y;
                cur.yaw = i_target_yaw;
                vehicle_poses_due.insert(vehicle_poses_due.size(), to_vehicle_frame(cur));
                void'(gps_targets.pop_front());
            end
            if (!i_valid || !o_stall) begin
                if (gps_targets.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid      <= 1'b1;
                    i_target_x   <= gps_targets[0].x;
                    i_target_y   <= gps_targets[0].y;
                    i_target_yaw <= gps_targets[0].yaw;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation,
    // then decide the stall for the next cycle. A long hold-off, once requested,
    // is counted down here so the pipeline fills and backs up into the input.
    always @(posedge i_clk) begin
        t_target_pose want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (vehicle_poses_due.size() == 0) begin
                    mismatches++;
                    $error("result transfer with no pose expected");
                end else begin
                    want = vehicle_poses_due.pop_front();
                    check_field("out_x", want.x, o_out_x);
                    check_field("out_y", want.y, o_out_y);
                    check_field("out_yaw", want.yaw, o_out_yaw);
                end
            end
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Count cycles without any transfer on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: give up when nothing has moved for too long
    initial begin
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("** gps_to_vehicle_pose_transform: FAILED **");
        $finish;
    end

    // Sequence: reset, directed poses under three settings, then random phases
    initial begin
        int          p;
        int          n;
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tyaw;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: offset mode, zero pose, so x passes through and y comes out negated
        queue_target('0, '0, '0);
        queue_target(WORD_MAX, WORD_MAX, WORD_MAX);
        queue_target(WORD_MIN, WORD_MIN, WORD_MIN);
        queue_target(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_target(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        wait_idle();

        // Plain mode with heading pi: walk the yaw correction and wrap edges.
        // Also poke the undecoded index, which must leave the settings alone.
        write_reg(gtvp_pkg::CFG_USE_OFFSET, 32'd0);
        write_reg(gtvp_pkg::CFG_REF_YAW, PI_A);
        write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        queue_target(WORD_MAX, WORD_MIN, PI_A - (TWO_PI_A + 1));   // just above 2*pi
        queue_target(WORD_MIN, WORD_MAX, PI_A - TWO_PI_A);         // exactly 2*pi
        queue_target('0, 32'hFFFF_FFFF, PI_A + TWO_PI_A + 1);      // just below -2*pi
        queue_target(32'h0001_0000, '0, 32'hFFFF_FFFF);            // pi + 1
        queue_target('0, 32'h0001_0000, '0);                       // exactly pi
        queue_target(32'h0123_4567, 32'hFEDC_BA98, PI_A + TWO_PI_A); // exactly -2*pi
        queue_target(32'hFFFF_0000, 32'h0000_FFFF, PI_A + TWO_PI_A + 1); // just below -2*pi
        queue_target(32'h0000_8000, 32'hFFFF_8000, WORD_MIN);      // stays out of range
        queue_target(32'h7FFF_0000, 32'h8000_FFFF, WORD_MAX);
        wait_idle();

        // Offset mode at the extremes: differences exceed 32 bits and outputs may saturate
        write_reg(gtvp_pkg::CFG_REF_X, WORD_MAX);
        write_reg(gtvp_pkg::CFG_REF_Y, WORD_MIN);
        write_reg(gtvp_pkg::CFG_REF_YAW, WORD_MIN);
        write_reg(gtvp_pkg::CFG_OFFSET_X, WORD_MAX);
        write_reg(gtvp_pkg::CFG_OFFSET_Y, WORD_MIN);
        write_reg(gtvp_pkg::CFG_OFFSET_YAW, WORD_MAX);
        write_reg(gtvp_pkg::CFG_USE_OFFSET, 32'd1);
        queue_target(WORD_MIN, WORD_MAX, '0);
        queue_target(WORD_MAX, WORD_MIN, WORD_MAX);
        queue_target('0, '0, WORD_MIN);
        queue_target(WORD_MAX, WORD_MAX, WORD_MAX);
        queue_target(WORD_MIN, WORD_MIN, WORD_MIN);

        // Random phases: a fresh setting each, idling pattern changes every two
        for (p = 0; p < 6; p++) begin
            wait_idle();
            if (p < 2) begin
                send_idle_pct  = 7;
                recv_stall_pct = 65;
            end else if (p < 4) begin
                send_idle_pct  = 65;
                recv_stall_pct = 7;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_reg(gtvp_pkg::CFG_REF_X, pick_pos());
            write_reg(gtvp_pkg::CFG_REF_Y, pick_pos());
            write_reg(gtvp_pkg::CFG_REF_YAW, pick_angle());
            write_reg(gtvp_pkg::CFG_OFFSET_X, pick_pos());
            write_reg(gtvp_pkg::CFG_OFFSET_Y, pick_pos());
            write_reg(gtvp_pkg::CFG_OFFSET_YAW, pick_angle());
            write_reg(gtvp_pkg::CFG_USE_OFFSET, p % 2);

            // Back up the pipeline: the receiver holds off while poses keep coming
            if (p == 4)
                hold_reqs++;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Pause the sender halfway until the block has drained
                if (p == 5 && n == PHASE_ITEMS / 2)
                    wait_idle();
                if ($urandom_range(0, 9) < 7) begin
                    tx = ref_x_r + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
                    ty = ref_y_r + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
                end else begin
                    tx = pick_pos();
                    ty = pick_pos();
                end
                if ($urandom_range(0, 1) == 0)
                    tyaw = ref_yaw_r - ($urandom_range(0, 5 * TWO_PI_A) - (5 * TWO_PI_A) / 2);
                else
                    tyaw = pick_angle();
                queue_target(tx, ty, tyaw);
            end
        end

        wait_idle();
        // Let any stray result surface before the verdict
        repeat (ROT_STEPS + 30) @(posedge i_clk);
        if (mismatches == 0)
            $display("** gps_to_vehicle_pose_transform: PASSED **");
        else
            $display("** gps_to_vehicle_pose_transform: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
